// ===== hdl/mfb_pkg.sv =====
// Shared types and constants for the monochrome framebuffer flush unit.
package mfb_pkg;

  // Vertical page layout: one byte holds eight rows of one column
  localparam int PAGES       = 8;
  localparam int PAGE_W      = 3;
  localparam int BYTE_W      = 8;
  localparam int COL_OUT_W   = 7;
  localparam int COL_BYTES_W = PAGES * BYTE_W;

  // Operation codes
  typedef enum logic [1:0] {
    MODE_DRAW  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_FLUSH = 2'd3
  } mode_t;

  // Draw shades
  typedef enum logic [1:0] {
    SHADE_BLACK  = 2'd0,
    SHADE_WHITE  = 2'd1,
    SHADE_INVERT = 2'd2,
    SHADE_NONE   = 2'd3
  } shade_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DRAW,
    ST_READ,
    ST_CLEAR,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_SEND,
    ST_DRAIN
  } state_t;

endpackage

// ===== hdl/mono_framebuffer_dirty_rect_flush_unit.sv =====
// Monochrome framebuffer with read-modify-write pixel ops and dirty-rectangle flush.
//
//  channel  | handshake              | fields
//  ---------+------------------------+------------------------------------------------
//  request  | start, busy            | in_mode, in_pos_x, in_pos_y, in_shade,
//           |                        | in_only_changes
//  result   | out_strobe (1 cycle)   | out_kind, out_pixel_white, out_window_*,
//           |                        | out_*_column_bytes, out_columns_in_result, out_last
//
// Read: the reply strobes in the first cycle busy is low again. Transparent or off-screen
// draws and flag-clear flushes never raise busy. Clear sweeps every byte of mem_now.
// Full flush: one memory read per byte, two columns (16 bytes) per result.
// Changes flush: a scan of both stores, then one memory read per window byte.
// After reset both stores are cleared by a sweep over every address; busy stays high.
// The receiver cannot stall; results come at most one per cycle.
module mono_framebuffer_dirty_rect_flush_unit #(
  parameter int WIDTH  = 128,
  parameter int HEIGHT = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_mode,
  input  logic signed [15:0]                 in_pos_x,
  input  logic signed [15:0]                 in_pos_y,
  input  logic [1:0]                         in_shade,
  input  logic                               in_only_changes,
  output logic                               out_strobe,
  output logic [1:0]                         out_kind,
  output logic                               out_pixel_white,
  output logic [mfb_pkg::COL_OUT_W-1:0]      out_window_first_column,
  output logic [mfb_pkg::COL_OUT_W-1:0]      out_window_last_column,
  output logic [mfb_pkg::PAGE_W-1:0]         out_window_first_page,
  output logic [mfb_pkg::PAGE_W-1:0]         out_window_last_page,
  output logic [mfb_pkg::COL_BYTES_W-1:0]    out_first_column_bytes,
  output logic [mfb_pkg::COL_BYTES_W-1:0]    out_second_column_bytes,
  output logic [1:0]                         out_columns_in_result,
  output logic                               out_last
);
  import mfb_pkg::*;

  localparam int CW    = $clog2(WIDTH);
  localparam int AW    = CW + PAGE_W;
  localparam int DEPTH = WIDTH * PAGES;

  // Frame stores
  logic [BYTE_W-1:0] mem_now  [DEPTH];
  logic [BYTE_W-1:0] mem_sent [DEPTH];

  state_t state_r, state_nxt;

  logic              changed_r;
  logic [AW-1:0]     addr_r;
  logic [AW-1:0]     draw_addr_r;
  logic [PAGE_W-1:0] pix_bit_r;
  logic [1:0]        draw_shade_r;
  logic              read_on_r;

  // Window bounds (scan result or full frame)
  logic [CW-1:0]     cmin_r, cmax_r;
  logic [PAGE_W-1:0] pmin_r, pmax_r;
  logic              any_r;

  // Send issue stage
  logic [CW-1:0]     send_col_r;
  logic [PAGE_W-1:0] send_page_r;
  logic              send_slot_r;

  // Send data stage
  logic              d_valid_r, d_slot_r, d_end_r, d_last_r;
  logic [AW-1:0]     d_addr_r;
  logic [PAGE_W-1:0] d_lane_r;
  logic [PAGES-1:0][BYTE_W-1:0] acc0_r, acc1_r, acc0_nxt, acc1_nxt;

  // Scan data stage
  logic              sc_valid_r;
  logic [AW-1:0]     sc_addr_r;

  // Memory ports
  logic [AW-1:0]     now_raddr, now_waddr, sent_waddr;
  logic [BYTE_W-1:0] now_wdata, sent_wdata, now_rdata, sent_rdata;
  logic              now_we, sent_we;

  // Output registers
  logic              out_strobe_r, out_pixel_white_r, out_last_r;
  logic [1:0]        out_kind_r, out_columns_in_result_r;
  logic [COL_OUT_W-1:0]   out_wfc_r, out_wlc_r;
  logic [PAGE_W-1:0]      out_wfp_r, out_wlp_r;
  logic [COL_BYTES_W-1:0] out_fcb_r, out_scb_r;

  // Request decode
  logic          accept, on_screen, draw_hit;
  logic [AW-1:0] in_addr;
  logic          send_col_end, sc_diff;
  logic [CW-1:0]     sc_col;
  logic [PAGE_W-1:0] sc_page;
  logic [BYTE_W-1:0] draw_mask;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign on_screen = !in_pos_x[15] && (in_pos_x[14:0] < 15'(WIDTH)) &&
                     !in_pos_y[15] && (in_pos_y[14:0] < 15'(HEIGHT));
  assign in_addr   = {in_pos_x[CW-1:0], in_pos_y[5:3]};
  assign draw_hit  = on_screen && (shade_t'(in_shade) != SHADE_NONE);
  assign draw_mask = BYTE_W'(1) << pix_bit_r;
  assign send_col_end = (send_page_r == pmax_r);
  assign sc_col  = sc_addr_r[AW-1:PAGE_W];
  assign sc_page = sc_addr_r[PAGE_W-1:0];
  assign sc_diff = sc_valid_r && (now_rdata != sent_rdata);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (addr_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (mode_t'(in_mode))
            MODE_DRAW:  if (draw_hit) state_nxt = ST_DRAW;
            MODE_READ:  state_nxt = ST_READ;
            MODE_CLEAR: state_nxt = ST_CLEAR;
            MODE_FLUSH: begin
              if (!in_only_changes) state_nxt = ST_SEND;
              else if (changed_r)   state_nxt = ST_SCAN;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_DRAW:  state_nxt = ST_IDLE;
      ST_READ:  state_nxt = ST_IDLE;
      ST_CLEAR: begin
        if (addr_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (addr_r == AW'(DEPTH - 1)) state_nxt = ST_SCAN_END;
      end
      ST_SCAN_END: state_nxt = ST_DECIDE;
      ST_DECIDE:   state_nxt = any_r ? ST_SEND : ST_IDLE;
      ST_SEND: begin
        if (send_col_end && (send_col_r == cmax_r)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Memory port control
  always_comb begin
    now_raddr  = addr_r;
    now_we     = 1'b0;
    now_waddr  = addr_r;
    now_wdata  = '0;
    sent_we    = 1'b0;
    sent_waddr = addr_r;
    sent_wdata = '0;
    case (state_r)
      ST_INIT: begin
        now_we  = 1'b1;
        sent_we = 1'b1;
      end
      ST_IDLE:  now_raddr = in_addr;
      ST_CLEAR: now_we = 1'b1;
      ST_DRAW: begin
        now_we    = 1'b1;
        now_waddr = draw_addr_r;
        case (shade_t'(draw_shade_r))
          SHADE_WHITE:  now_wdata = now_rdata | draw_mask;
          SHADE_BLACK:  now_wdata = now_rdata & ~draw_mask;
          default:      now_wdata = now_rdata ^ draw_mask;
        endcase
      end
      ST_SEND: now_raddr = {send_col_r, send_page_r};
      default: now_raddr = addr_r;
    endcase
    // sent copy follows each byte on its way out
    if (d_valid_r) begin
      sent_we    = 1'b1;
      sent_waddr = d_addr_r;
      sent_wdata = now_rdata;
    end
  end

  // Frame stores, registered read
  always_ff @(posedge clk) begin
    if (now_we) mem_now[now_waddr] <= now_wdata;
    now_rdata <= mem_now[now_raddr];
  end

  always_ff @(posedge clk) begin
    if (sent_we) mem_sent[sent_waddr] <= sent_wdata;
    sent_rdata <= mem_sent[addr_r];
  end

  // Column accumulators: byte lands in its page lane
  always_comb begin
    acc0_nxt = acc0_r;
    acc1_nxt = acc1_r;
    if (d_valid_r) begin
      if (d_slot_r) acc1_nxt[d_lane_r] = now_rdata;
      else          acc0_nxt[d_lane_r] = now_rdata;
    end
  end

  // Control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      addr_r       <= '0;
      changed_r    <= 1'b0;
      d_valid_r    <= 1'b0;
      sc_valid_r   <= 1'b0;
      out_strobe_r <= 1'b0;
      acc0_r       <= '0;
      acc1_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= 1'b0;
      d_valid_r    <= 1'b0;
      sc_valid_r   <= (state_r == ST_SCAN);
      sc_addr_r    <= addr_r;

      // sweep counter for init, clear and scan
      if (state_r == ST_INIT || state_r == ST_CLEAR || state_r == ST_SCAN) begin
        addr_r <= (addr_r == AW'(DEPTH - 1)) ? '0 : addr_r + AW'(1);
      end

      // request intake
      if (accept) begin
        draw_addr_r  <= in_addr;
        pix_bit_r    <= in_pos_y[PAGE_W-1:0];
        draw_shade_r <= in_shade;
        read_on_r    <= on_screen;
        case (mode_t'(in_mode))
          MODE_DRAW:  if (draw_hit) changed_r <= 1'b1;
          MODE_CLEAR: begin
            changed_r <= 1'b1;
            addr_r    <= '0;
          end
          MODE_FLUSH: begin
            if (!in_only_changes) begin
              changed_r   <= 1'b0;
              cmin_r      <= '0;
              cmax_r      <= CW'(WIDTH - 1);
              pmin_r      <= '0;
              pmax_r      <= PAGE_W'(PAGES - 1);
              send_col_r  <= '0;
              send_page_r <= '0;
              send_slot_r <= 1'b0;
            end else if (changed_r) begin
              changed_r <= 1'b0;
              addr_r    <= '0;
              any_r     <= 1'b0;
              pmin_r    <= PAGE_W'(PAGES - 1);
              pmax_r    <= '0;
            end else begin
              out_strobe_r            <= 1'b1;
              out_kind_r              <= KIND_EMPTY;
              out_pixel_white_r       <= 1'b0;
              out_wfc_r               <= '0;
              out_wlc_r               <= '0;
              out_wfp_r               <= '0;
              out_wlp_r               <= '0;
              out_fcb_r               <= '0;
              out_scb_r               <= '0;
              out_columns_in_result_r <= '0;
              out_last_r              <= 1'b1;
            end
          end
          default: ;
        endcase
      end

      // pixel read reply
      if (state_r == ST_READ) begin
        out_strobe_r            <= 1'b1;
        out_kind_r              <= KIND_READ;
        out_pixel_white_r       <= read_on_r && now_rdata[pix_bit_r];
        out_wfc_r               <= '0;
        out_wlc_r               <= '0;
        out_wfp_r               <= '0;
        out_wlp_r               <= '0;
        out_fcb_r               <= '0;
        out_scb_r               <= '0;
        out_columns_in_result_r <= '0;
        out_last_r              <= 1'b1;
      end

      // scan compare: columns arrive in order, pages tracked by min/max
      if (sc_diff) begin
        any_r  <= 1'b1;
        if (!any_r) cmin_r <= sc_col;
        cmax_r <= sc_col;
        if (sc_page < pmin_r) pmin_r <= sc_page;
        if (sc_page > pmax_r) pmax_r <= sc_page;
      end

      // scan outcome
      if (state_r == ST_DECIDE) begin
        if (any_r) begin
          send_col_r  <= cmin_r;
          send_page_r <= pmin_r;
          send_slot_r <= 1'b0;
        end else begin
          out_strobe_r            <= 1'b1;
          out_kind_r              <= KIND_EMPTY;
          out_pixel_white_r       <= 1'b0;
          out_wfc_r               <= '0;
          out_wlc_r               <= '0;
          out_wfp_r               <= '0;
          out_wlp_r               <= '0;
          out_fcb_r               <= '0;
          out_scb_r               <= '0;
          out_columns_in_result_r <= '0;
          out_last_r              <= 1'b1;
        end
      end

      // send issue: one byte read per cycle
      if (state_r == ST_SEND) begin
        d_valid_r <= 1'b1;
        d_addr_r  <= {send_col_r, send_page_r};
        d_lane_r  <= send_page_r - pmin_r;
        d_slot_r  <= send_slot_r;
        d_end_r   <= send_col_end && (send_slot_r || (send_col_r == cmax_r));
        d_last_r  <= send_col_end && (send_col_r == cmax_r);
        if (send_col_end) begin
          send_page_r <= pmin_r;
          send_col_r  <= send_col_r + CW'(1);
          send_slot_r <= !send_slot_r;
        end else begin
          send_page_r <= send_page_r + PAGE_W'(1);
        end
      end

      // send data: pack bytes, emit every one or two columns
      if (d_valid_r) begin
        if (d_end_r) begin
          acc0_r                  <= '0;
          acc1_r                  <= '0;
          out_strobe_r            <= 1'b1;
          out_kind_r              <= KIND_DATA;
          out_pixel_white_r       <= 1'b0;
          out_wfc_r               <= COL_OUT_W'(cmin_r);
          out_wlc_r               <= COL_OUT_W'(cmax_r);
          out_wfp_r               <= pmin_r;
          out_wlp_r               <= pmax_r;
          out_fcb_r               <= acc0_nxt;
          out_scb_r               <= acc1_nxt;
          out_columns_in_result_r <= d_slot_r ? 2'd2 : 2'd1;
          out_last_r              <= d_last_r;
        end else begin
          acc0_r <= acc0_nxt;
          acc1_r <= acc1_nxt;
        end
      end
    end
  end

  assign out_strobe              = out_strobe_r;
  assign out_kind                = out_kind_r;
  assign out_pixel_white         = out_pixel_white_r;
  assign out_window_first_column = out_wfc_r;
  assign out_window_last_column  = out_wlc_r;
  assign out_window_first_page   = out_wfp_r;
  assign out_window_last_page    = out_wlp_r;
  assign out_first_column_bytes  = out_fcb_r;
  assign out_second_column_bytes = out_scb_r;
  assign out_columns_in_result   = out_columns_in_result_r;
  assign out_last                = out_last_r;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the monochrome framebuffer dirty-rectangle flush unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mfb_pkg::*;

  localparam int FB_WIDTH  = 128;
  localparam int FB_HEIGHT = 64;
  localparam int STORE     = FB_WIDTH * PAGES;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  // Longest internal sweep (clear or changes flush) plus margin
  localparam int SETTLE_CYCLES = 2 * STORE + 200;

  // One result as seen on the output ports
  typedef struct packed {
    logic [1:0]             kind;
    logic                   white;
    logic [COL_OUT_W-1:0]   col_first;
    logic [COL_OUT_W-1:0]   col_last;
    logic [PAGE_W-1:0]      page_first;
    logic [PAGE_W-1:0]      page_last;
    logic [COL_BYTES_W-1:0] bytes_a;
    logic [COL_BYTES_W-1:0] bytes_b;
    logic [1:0]             ncols;
    logic                   last;
  } fb_result_t;

  // Frame mirror plus the queue of results it predicts
  class flush_scoreboard;
    bit [7:0]   frame_live [STORE];
    bit [7:0]   frame_shown [STORE];
    bit         dirty;
    fb_result_t awaited [$];
    int         errors;

    function string show(fb_result_t r);
      return $sformatf("kind=%0d white=%b cols=%0d..%0d pages=%0d..%0d a=%h b=%h n=%0d last=%b",
                       r.kind, r.white, r.col_first, r.col_last, r.page_first,
                       r.page_last, r.bytes_a, r.bytes_b, r.ncols, r.last);
    endfunction

    function void flag_error(string msg);
      errors++;
      if (errors <= 10)
        $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    function void push_simple(kind_t kind, bit white);
      fb_result_t r;
      r = '0;
      r.kind  = kind;
      r.white = white;
      r.last  = 1'b1;
      awaited.push_back(r);
    endfunction

    // Packs one column's pages and marks them as sent
    function bit [COL_BYTES_W-1:0] take_column(int col, int p0, int p1);
      bit [COL_BYTES_W-1:0] acc;
      int i;
      acc = '0;
      for (int p = p0; p <= p1; p++) begin
        i = col * PAGES + p;
        acc |= COL_BYTES_W'(frame_live[i]) << (8 * (p - p0));
        frame_shown[i] = frame_live[i];
      end
      return acc;
    endfunction

    // Two columns per result across the window
    function void push_window(int c0, int c1, int p0, int p1);
      fb_result_t r;
      int c;
      c = c0;
      while (c <= c1) begin
        r = '0;
        r.kind       = KIND_DATA;
        r.col_first  = COL_OUT_W'(c0);
        r.col_last   = COL_OUT_W'(c1);
        r.page_first = PAGE_W'(p0);
        r.page_last  = PAGE_W'(p1);
        r.bytes_a    = take_column(c, p0, p1);
        if (c + 1 <= c1) begin
          r.bytes_b = take_column(c + 1, p0, p1);
          r.ncols   = 2'd2;
        end else begin
          r.ncols = 2'd1;
        end
        c += int'(r.ncols);
        r.last = (c > c1);
        awaited.push_back(r);
      end
    endfunction

    // Applies one accepted request to the mirror
    function void note_request(logic [1:0] mode, logic signed [15:0] px,
                               logic signed [15:0] py, logic [1:0] shade, logic only);
      int x, y, idx;
      int cmin, cmax, pmin, pmax;
      bit on;
      bit [7:0] mask;
      x = int'(px);
      y = int'(py);
      on = (x >= 0 && x < FB_WIDTH && y >= 0 && y < FB_HEIGHT);
      idx = 0;
      mask = '0;
      if (on) begin
        idx  = x * PAGES + y / 8;
        mask = 8'd1 << (y % 8);
      end
      case (mode)
        MODE_DRAW: begin
          if (on && shade != SHADE_NONE) begin
            dirty = 1'b1;
            case (shade)
              SHADE_WHITE: frame_live[idx] |= mask;
              SHADE_BLACK: frame_live[idx] &= ~mask;
              default:     frame_live[idx] ^= mask;
            endcase
          end
        end
        MODE_READ: push_simple(KIND_READ, on && (frame_live[idx] & mask) != 0);
        MODE_CLEAR: begin
          foreach (frame_live[i]) frame_live[i] = '0;
          dirty = 1'b1;
        end
        default: begin
          if (only && !dirty) begin
            push_simple(KIND_EMPTY, 1'b0);
          end else begin
            dirty = 1'b0;
            if (!only) begin
              push_window(0, FB_WIDTH - 1, 0, PAGES - 1);
            end else begin
              // bounding box of bytes that differ from the sent copy
              cmin = FB_WIDTH;
              cmax = -1;
              pmin = PAGES;
              pmax = -1;
              for (int c = 0; c < FB_WIDTH; c++)
                for (int p = 0; p < PAGES; p++)
                  if (frame_live[c * PAGES + p] != frame_shown[c * PAGES + p]) begin
                    if (c < cmin) cmin = c;
                    if (c > cmax) cmax = c;
                    if (p < pmin) pmin = p;
                    if (p > pmax) pmax = p;
                  end
              if (cmax < 0)
                push_simple(KIND_EMPTY, 1'b0);
              else
                push_window(cmin, cmax, pmin, pmax);
            end
          end
        end
      endcase
    endfunction

    function void check_result(fb_result_t got);
      fb_result_t want;
      if (awaited.size() == 0) begin
        flag_error($sformatf("unexpected result %s", show(got)));
        return;
      end
      want = awaited.pop_front();
      if (got !== want)
        flag_error($sformatf("expected %s, got %s", show(want), show(got)));
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [1:0]             in_mode = MODE_DRAW;
  logic signed [15:0]     in_pos_x = '0;
  logic signed [15:0]     in_pos_y = '0;
  logic [1:0]             in_shade = SHADE_NONE;
  logic                   in_only_changes = 1'b0;
  logic                   out_strobe;
  logic [1:0]             out_kind;
  logic                   out_pixel_white;
  logic [COL_OUT_W-1:0]   out_window_first_column;
  logic [COL_OUT_W-1:0]   out_window_last_column;
  logic [PAGE_W-1:0]      out_window_first_page;
  logic [PAGE_W-1:0]      out_window_last_page;
  logic [COL_BYTES_W-1:0] out_first_column_bytes;
  logic [COL_BYTES_W-1:0] out_second_column_bytes;
  logic [1:0]             out_columns_in_result;
  logic                   out_last;

  flush_scoreboard sb;
  fb_result_t      seen;
  int              idle_pct = 0;
  int unsigned     cycle_count = 0;

  mono_framebuffer_dirty_rect_flush_unit #(
    .WIDTH (FB_WIDTH),
    .HEIGHT(FB_HEIGHT)
  ) dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_mode                (in_mode),
    .in_pos_x               (in_pos_x),
    .in_pos_y               (in_pos_y),
    .in_shade               (in_shade),
    .in_only_changes        (in_only_changes),
    .out_strobe             (out_strobe),
    .out_kind               (out_kind),
    .out_pixel_white        (out_pixel_white),
    .out_window_first_column(out_window_first_column),
    .out_window_last_column (out_window_last_column),
    .out_window_first_page  (out_window_first_page),
    .out_window_last_page   (out_window_last_page),
    .out_first_column_bytes (out_first_column_bytes),
    .out_second_column_bytes(out_second_column_bytes),
    .out_columns_in_result  (out_columns_in_result),
    .out_last               (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Request acceptance and result sampling, both on pre-edge values
  always @(posedge clk) begin
    if (rst_n && start && busy === 1'b0)
      sb.note_request(in_mode, in_pos_x, in_pos_y, in_shade, in_only_changes);
    if (rst_n && out_strobe !== 1'b0) begin
      seen.kind       = out_kind;
      seen.white      = out_pixel_white;
      seen.col_first  = out_window_first_column;
      seen.col_last   = out_window_last_column;
      seen.page_first = out_window_first_page;
      seen.page_last  = out_window_last_page;
      seen.bytes_a    = out_first_column_bytes;
      seen.bytes_b    = out_second_column_bytes;
      seen.ncols      = out_columns_in_result;
      seen.last       = out_last;
      sb.check_result(seen);
    end
  end

  // Presents one request, after a random idle gap, and waits for it to be taken
  task automatic issue(mode_t mode, int x, int y, shade_t shade, bit only);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_mode         <= mode;
    in_pos_x        <= x[15:0];
    in_pos_y        <= y[15:0];
    in_shade        <= shade;
    in_only_changes <= only;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Mostly near a focus point, sometimes on the clip edges or anywhere
  function automatic int pick_coord(int base, int span, int limit);
    int r;
    r = $urandom_range(99);
    if (r < 70)
      return base + $urandom_range(span);
    if (r < 82) begin
      case ($urandom_range(3))
        0: return 0;
        1: return limit - 1;
        2: return -1;
        default: return limit;
      endcase
    end
    return $urandom_range(16'hFFFF);
  endfunction

  initial begin
    int r, fx, fy, sx, sy;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    idle_pct = 37;

    // Directed: clipping, every shade, every flush outcome
    issue(MODE_READ,  0, 0, SHADE_NONE, 1'b0);
    issue(MODE_FLUSH, 0, 0, SHADE_NONE, 1'b1);            // nothing drawn yet
    issue(MODE_DRAW,  0, 0, SHADE_WHITE, 1'b0);
    issue(MODE_DRAW,  FB_WIDTH - 1, FB_HEIGHT - 1, SHADE_WHITE, 1'b1);
    issue(MODE_DRAW,  -1, 5, SHADE_WHITE, 1'b0);
    issue(MODE_DRAW,  FB_WIDTH, 5, SHADE_WHITE, 1'b0);
    issue(MODE_DRAW,  5, FB_HEIGHT, SHADE_INVERT, 1'b0);
    issue(MODE_DRAW,  -32768, 32767, SHADE_WHITE, 1'b1);
    issue(MODE_DRAW,  10, 10, SHADE_NONE, 1'b0);
    issue(MODE_READ,  0, 0, SHADE_NONE, 1'b0);
    issue(MODE_READ,  FB_WIDTH - 1, FB_HEIGHT - 1, SHADE_WHITE, 1'b1);
    issue(MODE_READ,  32767, -32768, SHADE_NONE, 1'b0);
    issue(MODE_FLUSH, 0, 0, SHADE_NONE, 1'b1);            // box spans the frame
    issue(MODE_FLUSH, 0, 0, SHADE_NONE, 1'b1);            // flag clear
    issue(MODE_DRAW,  40, 20, SHADE_INVERT, 1'b0);
    issue(MODE_DRAW,  40, 20, SHADE_INVERT, 1'b0);
    issue(MODE_FLUSH, 0, 0, SHADE_NONE, 1'b1);            // flag set, no byte differs
    issue(MODE_DRAW,  63, 9, SHADE_WHITE, 1'b0);
    issue(MODE_DRAW,  64, 30, SHADE_BLACK, 1'b0);
    issue(MODE_FLUSH, 0, 0, SHADE_NONE, 1'b1);            // single column window
    issue(MODE_CLEAR, 0, 0, SHADE_NONE, 1'b0);
    issue(MODE_READ,  63, 9, SHADE_NONE, 1'b0);
    issue(MODE_FLUSH, 0, 0, SHADE_NONE, 1'b1);
    issue(MODE_DRAW,  7, 7, SHADE_INVERT, 1'b0);
    issue(MODE_FLUSH, 0, 0, SHADE_NONE, 1'b0);            // whole frame

    // Random: draws clustered in a box, reads, the odd clear, flushes
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 37 : (phase == 1) ? 69 : 0;
      fx = $urandom_range(FB_WIDTH - 1);
      fy = $urandom_range(FB_HEIGHT - 1);
      sx = $urandom_range(15);
      sy = $urandom_range(15);
      for (int n = 0; n < 100; n++) begin
        r = $urandom_range(99);
        if (r < 52) begin
          issue(MODE_DRAW, pick_coord(fx, sx, FB_WIDTH), pick_coord(fy, sy, FB_HEIGHT),
                shade_t'($urandom_range(3)), 1'($urandom_range(1)));
        end else if (r < 78) begin
          issue(MODE_READ, pick_coord(fx, sx, FB_WIDTH), pick_coord(fy, sy, FB_HEIGHT),
                shade_t'($urandom_range(3)), 1'($urandom_range(1)));
        end else if (r < 82) begin
          issue(MODE_CLEAR, $urandom_range(16'hFFFF), $urandom_range(16'hFFFF),
                shade_t'($urandom_range(3)), 1'($urandom_range(1)));
        end else begin
          issue(MODE_FLUSH, $urandom_range(16'hFFFF), $urandom_range(16'hFFFF),
                shade_t'($urandom_range(3)), $urandom_range(3) != 0);
          // move the drawing area after each flush
          fx = $urandom_range(FB_WIDTH - 1);
          fy = $urandom_range(FB_HEIGHT - 1);
          sx = $urandom_range(15);
          sy = $urandom_range(15);
        end
      end
    end
    start <= 1'b0;

    // Drain, then watch for stray results
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
